// ===== hdl/abmd_pkg.sv =====
// Package for the add/subtract/Booth multiply/restoring divide unit.
// Holds the operation codes and the control struct that rides the pipeline.
// No dependencies.
`default_nettype none

package abmd_pkg;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    // Per-item control carried alongside the data in every stage.
    typedef struct packed {
        logic valid;
        cmd_t cmd;
        logic neg;   // divisor was negative, quotient gets negated at the end
        logic tail;  // Booth extra bit to the right of the multiplier
    } ctl_t;

endpackage

`default_nettype wire

// ===== hdl/alu_add_sub_booth_mul_restoring_div_top.sv =====
// Top level of the add/subtract/Booth multiply/restoring divide unit.
// Instantiates abmd_front, WIDTH copies of abmd_stage and abmd_back; uses abmd_pkg.
//
// An item is taken at any clock edge with start high; busy is always low, so
// one item can be issued every cycle. Each item yields one result on
// result_low/result_high, shown for a single cycle with done high, in issue order.
// An item passes through one entry register, one register per Booth/division
// step (WIDTH of them), and one output register. The receiver cannot stall, so
// results must be captured in the cycle done is high.
`default_nettype none

module alu_add_sub_booth_mul_restoring_div_top #(
    parameter int WIDTH = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         cmd,
    input  wire logic [WIDTH-1:0]   operand_a,
    input  wire logic [WIDTH-1:0]   operand_b,
    output logic                    done,
    output logic      [WIDTH-1:0]   result_low,
    output logic      [WIDTH-1:0]   result_high
);

    abmd_pkg::ctl_t   ctl_s [0:WIDTH];
    logic [WIDTH-1:0] m_s   [0:WIDTH];
    logic [WIDTH-1:0] sum_s [0:WIDTH];
    logic [WIDTH-1:0] acc_s [0:WIDTH];
    logic [WIDTH-1:0] qm_s  [0:WIDTH];
    logic [WIDTH-1:0] r_s   [0:WIDTH];
    logic [WIDTH-1:0] qd_s  [0:WIDTH];
    logic [WIDTH-1:0] d_s   [0:WIDTH];

    assign busy = 1'b0;

    abmd_front #(.WIDTH(WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (start && !busy),
        .cmd       (cmd),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .ctl       (ctl_s[0]),
        .m         (m_s[0]),
        .sum       (sum_s[0]),
        .acc       (acc_s[0]),
        .qm        (qm_s[0]),
        .r         (r_s[0]),
        .qd        (qd_s[0]),
        .d         (d_s[0])
    );

    for (genvar i = 0; i < WIDTH; i++)
    begin : g_step
        abmd_stage #(.WIDTH(WIDTH)) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_s[i]),
            .m_in    (m_s[i]),
            .sum_in  (sum_s[i]),
            .acc_in  (acc_s[i]),
            .qm_in   (qm_s[i]),
            .r_in    (r_s[i]),
            .qd_in   (qd_s[i]),
            .d_in    (d_s[i]),
            .ctl_out (ctl_s[i+1]),
            .m_out   (m_s[i+1]),
            .sum_out (sum_s[i+1]),
            .acc_out (acc_s[i+1]),
            .qm_out  (qm_s[i+1]),
            .r_out   (r_s[i+1]),
            .qd_out  (qd_s[i+1]),
            .d_out   (d_s[i+1])
        );
    end

    // The last stage's multiplicand and divisor are no longer needed.
    abmd_back #(.WIDTH(WIDTH)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl_s[WIDTH]),
        .sum         (sum_s[WIDTH]),
        .acc         (acc_s[WIDTH]),
        .qm          (qm_s[WIDTH]),
        .r           (r_s[WIDTH]),
        .qd          (qd_s[WIDTH]),
        .done        (done),
        .result_low  (result_low),
        .result_high (result_high)
    );

    logic unused_tail;
    assign unused_tail = ^{m_s[WIDTH], d_s[WIDTH]};

endmodule

`default_nettype wire

// ===== hdl/abmd_front.sv =====
// Entry stage: registers an accepted item and sets up the recurrences.
// Computes the add/subtract result and the divisor magnitude. Uses abmd_pkg.
`default_nettype none

module abmd_front #(
    parameter int WIDTH = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic [1:0]           cmd,
    input  wire logic [WIDTH-1:0]     operand_a,
    input  wire logic [WIDTH-1:0]     operand_b,
    output abmd_pkg::ctl_t            ctl,
    output logic      [WIDTH-1:0]     m,
    output logic      [WIDTH-1:0]     sum,
    output logic      [WIDTH-1:0]     acc,
    output logic      [WIDTH-1:0]     qm,
    output logic      [WIDTH-1:0]     r,
    output logic      [WIDTH-1:0]     qd,
    output logic      [WIDTH-1:0]     d
);

    abmd_pkg::ctl_t   ctl_reg, ctl_next;
    logic [WIDTH-1:0] m_reg, sum_reg, sum_next, qm_reg, qd_reg, d_reg, d_next;

    always_comb
    begin
        ctl_next.valid = accept;
        ctl_next.cmd   = abmd_pkg::cmd_t'(cmd);
        ctl_next.neg   = operand_b[WIDTH-1];
        ctl_next.tail  = 1'b0;
        d_next   = operand_b[WIDTH-1] ? (~operand_b + 1'b1) : operand_b;
        sum_next = (cmd == abmd_pkg::CMD_SUB) ? (operand_a - operand_b)
                                              : (operand_a + operand_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.valid <= 1'b0;
            ctl_reg.cmd   <= abmd_pkg::CMD_ADD;
            ctl_reg.neg   <= 1'b0;
            ctl_reg.tail  <= 1'b0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_reg   <= operand_a;
            sum_reg <= sum_next;
            qm_reg  <= operand_b;
            qd_reg  <= operand_a;
            d_reg   <= d_next;
        end
    end

    assign ctl = ctl_reg;
    assign m   = m_reg;
    assign sum = sum_reg;
    assign acc = '0;
    assign qm  = qm_reg;
    assign r   = '0;
    assign qd  = qd_reg;
    assign d   = d_reg;

endmodule

`default_nettype wire

// ===== hdl/abmd_stage.sv =====
// One pipeline stage: a single Booth radix-2 step and a single restoring
// division step, both registered. Uses abmd_pkg.
`default_nettype none

module abmd_stage #(
    parameter int WIDTH = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire abmd_pkg::ctl_t       ctl_in,
    input  wire logic [WIDTH-1:0]     m_in,
    input  wire logic [WIDTH-1:0]     sum_in,
    input  wire logic [WIDTH-1:0]     acc_in,
    input  wire logic [WIDTH-1:0]     qm_in,
    input  wire logic [WIDTH-1:0]     r_in,
    input  wire logic [WIDTH-1:0]     qd_in,
    input  wire logic [WIDTH-1:0]     d_in,
    output abmd_pkg::ctl_t            ctl_out,
    output logic      [WIDTH-1:0]     m_out,
    output logic      [WIDTH-1:0]     sum_out,
    output logic      [WIDTH-1:0]     acc_out,
    output logic      [WIDTH-1:0]     qm_out,
    output logic      [WIDTH-1:0]     r_out,
    output logic      [WIDTH-1:0]     qd_out,
    output logic      [WIDTH-1:0]     d_out
);

    abmd_pkg::ctl_t   ctl_reg, ctl_next;
    logic [WIDTH-1:0] m_reg, sum_reg, d_reg;
    logic [WIDTH-1:0] acc_reg, acc_next, qm_reg, qm_next;
    logic [WIDTH-1:0] r_reg, r_next, qd_reg, qd_next;
    logic [WIDTH-1:0] acc_sum, r_shift, r_trial;

    always_comb
    begin
        // Booth: add on 01, subtract on 10 (q0, tail), then arithmetic shift of acc:q.
        acc_sum = acc_in;
        if (!qm_in[0] && ctl_in.tail)
        begin
            acc_sum = acc_in + m_in;
        end
        else if (qm_in[0] && !ctl_in.tail)
        begin
            acc_sum = acc_in - m_in;
        end
        qm_next  = {acc_sum[0], qm_in[WIDTH-1:1]};
        acc_next = {acc_sum[WIDTH-1], acc_sum[WIDTH-1:1]};

        // Restoring division: the sign of the wrapped trial decides restore.
        r_shift = {r_in[WIDTH-2:0], qd_in[WIDTH-1]};
        r_trial = r_shift - d_in;
        qd_next = {qd_in[WIDTH-2:0], ~r_trial[WIDTH-1]};
        r_next  = r_trial[WIDTH-1] ? r_shift : r_trial;

        ctl_next      = ctl_in;
        ctl_next.tail = qm_in[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.valid <= 1'b0;
            ctl_reg.cmd   <= abmd_pkg::CMD_ADD;
            ctl_reg.neg   <= 1'b0;
            ctl_reg.tail  <= 1'b0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.valid)
        begin
            m_reg   <= m_in;
            sum_reg <= sum_in;
            d_reg   <= d_in;
            acc_reg <= acc_next;
            qm_reg  <= qm_next;
            r_reg   <= r_next;
            qd_reg  <= qd_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign m_out   = m_reg;
    assign sum_out = sum_reg;
    assign acc_out = acc_reg;
    assign qm_out  = qm_reg;
    assign r_out   = r_reg;
    assign qd_out  = qd_reg;
    assign d_out   = d_reg;

endmodule

`default_nettype wire

// ===== hdl/abmd_back.sv =====
// Output stage: selects the result for the operation, negates the quotient
// for a negative divisor, and registers the result with its strobe.
// Uses abmd_pkg.
`default_nettype none

module abmd_back #(
    parameter int WIDTH = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire abmd_pkg::ctl_t       ctl,
    input  wire logic [WIDTH-1:0]     sum,
    input  wire logic [WIDTH-1:0]     acc,
    input  wire logic [WIDTH-1:0]     qm,
    input  wire logic [WIDTH-1:0]     r,
    input  wire logic [WIDTH-1:0]     qd,
    output logic                      done,
    output logic      [WIDTH-1:0]     result_low,
    output logic      [WIDTH-1:0]     result_high
);

    logic             done_reg;
    logic [WIDTH-1:0] low_reg, low_next, high_reg, high_next;

    always_comb
    begin
        case (ctl.cmd)
            abmd_pkg::CMD_MUL:
            begin
                low_next  = qm;
                high_next = acc;
            end
            abmd_pkg::CMD_DIV:
            begin
                low_next  = ctl.neg ? (~qd + 1'b1) : qd;
                high_next = r;
            end
            default:
            begin
                low_next  = sum;
                high_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    assign done        = done_reg;
    assign result_low  = low_reg;
    assign result_high = high_reg;

endmodule

`default_nettype wire

// ===== hdl/abmd_checker.sv =====
// Port-level checker for the arithmetic unit, bound to its top level.
// Checks that busy stays low, strobe timing and add/subtract results. Uses abmd_pkg.
`default_nettype none

module abmd_checker #(
    parameter int WIDTH = 8
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic [1:0]       cmd,
    input wire logic [WIDTH-1:0] operand_a,
    input wire logic [WIDTH-1:0] operand_b,
    input wire logic             done,
    input wire logic [WIDTH-1:0] result_low,
    input wire logic [WIDTH-1:0] result_high
);

    localparam int LAT = WIDTH + 2;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised although the unit never stalls");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result strobe missing after an accepted item");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LAT !done)
        else $error("result strobe without an accepted item");

    a_add_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == abmd_pkg::CMD_ADD) |-> ##LAT
        (result_low == WIDTH'($past(operand_a, LAT) + $past(operand_b, LAT))
         && result_high == '0))
        else $error("wrong sum");

    a_sub_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == abmd_pkg::CMD_SUB) |-> ##LAT
        (result_low == WIDTH'($past(operand_a, LAT) - $past(operand_b, LAT))
         && result_high == '0))
        else $error("wrong difference");

endmodule

bind alu_add_sub_booth_mul_restoring_div_top abmd_checker #(.WIDTH(WIDTH)) u_abmd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .operand_a   (operand_a),
    .operand_b   (operand_b),
    .done        (done),
    .result_low  (result_low),
    .result_high (result_high)
);

`default_nettype wire
